[rtl/sarn_pkg.sv]
// types, widths and codes shared by the suffix array range narrowing block
package sarn_pkg;

   localparam int POS_W  = 13;
   localparam int BYTE_W = 8;

   typedef enum logic [1:0] {
      CMD_TEXT   = 2'd0,
      CMD_SUFFIX = 2'd1,
      CMD_CHAR   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SLOT,
      ST_TEXT,
      ST_CMP,
      ST_DONE
   } state_type;

   typedef struct packed {
      cmd_type                   command;
      logic [POS_W-1:0]          write_index;
      logic signed [BYTE_W-1:0]  text_byte;
      logic [POS_W-1:0]          suffix_start;
      logic signed [BYTE_W-1:0]  pattern_char;
      logic                      first_char;
      logic                      last_char;
      logic [POS_W-1:0]          range_start;
      logic [POS_W-1:0]          range_end;
      logic [POS_W-1:0]          start_offset;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0] match_low;
      logic [POS_W-1:0] match_high;
      logic             range_empty;
      logic             is_last;
   } rsp_type;

endpackage

[rtl/suffix_array_range_narrow_top.sv]
// suffix array range narrowing: text and suffix stores with a binary search sequencer
//
// Usage: text bytes (command text) and suffix array entries (command suffix) are
// loaded one word each on the req channel; neither gives an rsp word.
// Pattern characters (command char) then follow; first_char loads the start range
// and offset. Each character gives exactly one rsp word with the narrowed range,
// an empty flag and is_last echoed. csr_wr_en/csr_wr_data set the text length;
// write it only while the block is idle.
// Each character runs one lower bound and one upper bound binary search, each
// probe in three steps (suffix memory read, text memory read, compare and halve)
// on one shared compare unit, plus setup and handoff. An empty range skips the
// search and goes straight to the done state. req_stall is high while a
// character is being searched; the next word is taken as soon as the sequencer
// is idle.
// The rsp word sits in an output register; a stalled rsp holds it, and a search
// that finishes meanwhile waits in its done state until the register frees up.
// Reset (synchronous, active high) clears the range, offset, text length and the
// handshake state; the memories are not cleared and hold nothing until written.
module suffix_array_range_narrow_top
   import sarn_pkg::*;
#(
   parameter int MAX_TEXT = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [POS_W-1:0] csr_wr_data
);

   localparam int TA_W  = $clog2(MAX_TEXT);
   localparam int SA_W  = $clog2(MAX_TEXT + 1);
   localparam int RANGE_MAX = MAX_TEXT + 1;

   state_type state_ff, state_in;

   logic [POS_W-1:0] cur_low_ff, cur_low_in;
   logic [POS_W-1:0] cur_high_ff, cur_high_in;
   logic [POS_W-1:0] cur_off_ff, cur_off_in;
   logic [POS_W-1:0] text_len_ff;
   logic [POS_W-1:0] lo_ff, lo_in;
   logic [POS_W-1:0] hi_ff, hi_in;
   logic             upper_ff, upper_in;
   logic signed [BYTE_W-1:0] ch_ff, ch_in;
   logic             last_ff, last_in;
   logic             slot_oob_ff, slot_oob_in;
   logic             pos_oob_ff, pos_oob_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic [POS_W-1:0]  sfx_rd_ff;
   logic [BYTE_W-1:0] text_rd_ff;

   logic [BYTE_W-1:0] text_mem [MAX_TEXT];
   logic [POS_W-1:0]  sfx_mem  [MAX_TEXT+1];

   logic             req_take;
   logic             out_free;
   logic [POS_W:0]   mid_sum;
   logic [POS_W-1:0] mid;
   logic [31:0]      mid_wide;
   logic [POS_W:0]   pos;
   logic [31:0]      pos_wide;
   logic [31:0]      widx_wide;
   logic [POS_W-1:0] ld_low, ld_high, eff_low, eff_high, eff_off;
   logic signed [BYTE_W-1:0] probe_byte;
   logic             go_right;
   logic             search_live;

   function automatic logic [POS_W-1:0] sat_range(input logic [POS_W-1:0] v);
      if (32'(v) > 32'(RANGE_MAX)) begin
         return POS_W'(RANGE_MAX);
      end
      return v;
   endfunction

   assign req_take    = req_valid && !req_stall;
   assign req_stall   = (state_ff != ST_IDLE);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign mid_sum     = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid         = mid_sum[POS_W:1];
   assign mid_wide    = 32'(mid);
   assign pos         = {1'b0, sfx_rd_ff} + {1'b0, cur_off_ff};
   assign pos_wide    = 32'(pos);
   assign widx_wide   = 32'(req_data.write_index);
   assign search_live = (lo_ff < hi_ff);
   assign probe_byte  = pos_oob_ff ? '0 : signed'(text_rd_ff);
   assign go_right    = upper_ff ? (probe_byte <= ch_ff) : (probe_byte < ch_ff);

   assign ld_low   = sat_range(req_data.range_start);
   assign ld_high  = sat_range(req_data.range_end);
   assign eff_low  = req_data.first_char ? ld_low : cur_low_ff;
   assign eff_high = req_data.first_char ? ld_high : cur_high_ff;
   assign eff_off  = req_data.first_char ? req_data.start_offset : cur_off_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && req_data.command == CMD_CHAR) begin
               state_in = (eff_low < eff_high) ? ST_SLOT : ST_DONE;
            end
         end
         ST_SLOT: begin
            if (search_live) begin
               state_in = ST_TEXT;
            end else if (upper_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_TEXT: state_in = ST_CMP;
         ST_CMP:  state_in = ST_SLOT;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cur_low_in   = cur_low_ff;
      cur_high_in  = cur_high_ff;
      cur_off_in   = cur_off_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      upper_in     = upper_ff;
      ch_in        = ch_ff;
      last_in      = last_ff;
      slot_oob_in  = slot_oob_ff;
      pos_oob_in   = pos_oob_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && req_data.command == CMD_CHAR) begin
               cur_low_in  = eff_low;
               cur_high_in = eff_high;
               cur_off_in  = eff_off;
               lo_in       = eff_low;
               hi_in       = eff_high;
               upper_in    = 1'b0;
               ch_in       = req_data.pattern_char;
               last_in     = req_data.last_char;
            end
         end
         ST_SLOT: begin
            slot_oob_in = (mid_wide > 32'(MAX_TEXT));
            if (!search_live) begin
               if (!upper_ff) begin
                  // lower bound found, upper search runs over [low, old high)
                  cur_low_in = lo_ff;
                  hi_in      = cur_high_ff;
                  upper_in   = 1'b1;
               end else begin
                  cur_high_in = lo_ff;
                  if (cur_off_ff != '1) begin
                     cur_off_in = cur_off_ff + 1'b1;
                  end
               end
            end
         end
         ST_TEXT: begin
            pos_oob_in = slot_oob_ff || (pos_wide >= 32'(text_len_ff))
                         || (pos_wide >= 32'(MAX_TEXT));
         end
         ST_CMP: begin
            if (go_right) begin
               lo_in = mid + 1'b1;
            end else begin
               hi_in = mid;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.match_low   = cur_low_ff;
               rsp_data_in.match_high  = cur_high_ff;
               rsp_data_in.range_empty = (cur_low_ff >= cur_high_ff);
               rsp_data_in.is_last     = last_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_low_ff   <= '0;
         cur_high_ff  <= '0;
         cur_off_ff   <= '0;
         text_len_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         upper_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_low_ff   <= cur_low_in;
         cur_high_ff  <= cur_high_in;
         cur_off_ff   <= cur_off_in;
         rsp_valid_ff <= rsp_valid_in;
         upper_ff     <= upper_in;
         if (csr_wr_en) begin
            text_len_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      ch_ff       <= ch_in;
      last_ff     <= last_in;
      slot_oob_ff <= slot_oob_in;
      pos_oob_ff  <= pos_oob_in;
      rsp_data_ff <= rsp_data_in;
   end

   // text store
   always_ff @(posedge clock) begin
      if (req_take && req_data.command == CMD_TEXT && widx_wide < 32'(MAX_TEXT)) begin
         text_mem[widx_wide[TA_W-1:0]] <= req_data.text_byte;
      end
      if (state_ff == ST_TEXT) begin
         text_rd_ff <= text_mem[pos_wide[TA_W-1:0]];
      end
   end

   // suffix store
   always_ff @(posedge clock) begin
      if (req_take && req_data.command == CMD_SUFFIX
          && widx_wide <= 32'(MAX_TEXT)) begin
         sfx_mem[widx_wide[SA_W-1:0]] <= req_data.suffix_start;
      end
      if (state_ff == ST_SLOT) begin
         sfx_rd_ff <= sfx_mem[mid_wide[SA_W-1:0]];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a word leaves the done state only into a free output register
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("rsp word raised outside the done state");

   // probes only run on a nonempty search window
   a_probe_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TEXT || state_ff == ST_CMP) |-> (lo_ff < hi_ff))
      else $error("probe issued on an empty window");

   // the upper search never starts below the lower bound or past the old end
   a_upper_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SLOT && upper_ff) |-> (lo_ff >= cur_low_ff && hi_ff <= cur_high_ff))
      else $error("upper search window outside the current range");

   // a finished search advances the offset by one unless saturated
   a_offset_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SLOT && upper_ff && !search_live && cur_off_ff != '1)
      |=> (cur_off_ff == $past(cur_off_ff) + 1'b1))
      else $error("offset did not advance after a search");

endmodule
